// ----- design/wto_pkg.sv -----
// shared types and constants of the wavetable oscillator
`default_nettype none

package wto_pkg;

   localparam int ACTION_W  = 2;
   localparam int ADDR_W    = 10;
   localparam int FREQ_W    = 24;
   localparam int PHASE_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;

   // frequency is Q16.8 and freq_scale is Q16.16: drop 16 fraction bits
   localparam int INCR_SHIFT = 16;

   localparam logic [CSR_W-1:0]   FREQ_SCALE_RESET  = 32'd24932236;
   localparam logic [PHASE_W-1:0] START_PHASE_RESET = 32'd0;
   localparam logic               INTERP_RESET      = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD    = 2'd0,
      ACT_TICK    = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FREQ_SCALE    = 2'd0,
      CSR_START_PHASE   = 2'd1,
      CSR_INTERP_ENABLE = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ----- design/wto_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module wto_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/wavetable_oscillator.sv -----
// wavetable oscillator top level: wave store, phase accumulator, interpolation pipeline
// usage
//   req channel: one item per handshake; action load writes req_table_sample into
//   the wave store at req_table_address (low TABLE_BITS bits), tick returns one
//   sample at the current phase and then advances the phase by
//   frequency * freq_scale, restart loads start_phase into the phase.
//   rsp channel: one item per tick, none for load, restart or the unused code.
//   csr channel: always ready; index 0 freq_scale, 1 start_phase, 2 interp_enable;
//   the user must write them only while the block is idle; the block does not enforce it.
// timing
//   a tick passes stage 1, the store read, stages 3 and 4 and the output register to rsp.
//   one item per cycle sustained while rsp is not stalled; a load is visible to a
//   tick accepted the next cycle, since store writes and phase reads happen in the same stage.
//   two copies of the wave store give both interpolation taps in one read
// reset
//   phase goes to zero, registers to their defaults, pipeline empties; the
//   wave store is not cleared and must be loaded before it is played.
// stall
//   each stage moves on when the one after it is empty or moving, so bubbles
//   close up while rsp is stalled; req_ready drops once all stages are full.
`default_nettype none

module wavetable_oscillator #(
   parameter int TABLE_BITS  = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [wto_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [wto_pkg::ADDR_W-1:0]          req_table_address,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_table_sample,
   input  wire logic signed [wto_pkg::FREQ_W-1:0]   req_frequency,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]            rsp_sample_out,
   // configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [wto_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [wto_pkg::CSR_W-1:0]           csr_wdata
);

   import wto_pkg::*;

   localparam int DEPTH     = 1 << TABLE_BITS;
   localparam int FRAC_BITS = PHASE_W - TABLE_BITS;
   localparam int AEXT_W    = (TABLE_BITS > ADDR_W) ? TABLE_BITS : ADDR_W;
   localparam int SCALE_W   = CSR_W + 1;
   localparam int INCR_P_W  = FREQ_W + SCALE_W;
   localparam int DIFF_W    = SAMPLE_BITS + 1;
   localparam int INTERP_P_W = DIFF_W + FRAC_BITS + 1;

   // configuration registers
   logic [CSR_W-1:0]   freq_scale_ff;
   logic [PHASE_W-1:0] start_phase_ff;
   logic               interp_enable_ff;

   // phase accumulator
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;

   // stage handshake enables
   logic en1, en2, en3, en4, en_out;

   // stage 1: accepted item and its phase increment
   logic                          s1_v_ff;
   action_type                    s1_action_ff;
   logic [TABLE_BITS-1:0]         s1_addr_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [PHASE_W-1:0]            s1_incr_ff;
   logic signed [INCR_P_W-1:0]    incr_prod;
   logic [AEXT_W-1:0]             addr_ext;

   // stage 2: store read in flight
   logic                  s2_v_ff;
   logic                  s2_v_in;
   logic [FRAC_BITS-1:0]  s2_frac_ff;
   logic                  s2_interp_ff;
   logic [TABLE_BITS-1:0] rd_idx;
   logic [TABLE_BITS-1:0] rd_idx_next;
   logic                  wr_en;
   logic [SAMPLE_BITS-1:0] rd_a;
   logic [SAMPLE_BITS-1:0] rd_b;

   // stage 3: difference between taps
   logic                          s3_v_ff;
   logic signed [SAMPLE_BITS-1:0] s3_a_ff;
   logic signed [DIFF_W-1:0]      s3_diff_ff;
   logic signed [DIFF_W-1:0]      s3_diff_in;
   logic [FRAC_BITS-1:0]          s3_frac_ff;

   // stage 4: scaled difference
   logic                          s4_v_ff;
   logic signed [SAMPLE_BITS-1:0] s4_a_ff;
   logic signed [DIFF_W-1:0]      s4_term_ff;
   logic signed [INTERP_P_W-1:0]  interp_prod;

   // output register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic signed [DIFF_W-1:0]      sum_in;

   // ------------------------------------------------------------------
   // flow control: a stage loads when it is empty or draining
   // ------------------------------------------------------------------
   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en4       = !s4_v_ff || en_out;
   assign en3       = !s3_v_ff || en4;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_ready = en1;
   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_scale_ff    <= FREQ_SCALE_RESET;
         start_phase_ff   <= START_PHASE_RESET;
         interp_enable_ff <= INTERP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FREQ_SCALE:    freq_scale_ff    <= csr_wdata;
            CSR_START_PHASE:   start_phase_ff   <= csr_wdata[PHASE_W-1:0];
            CSR_INTERP_ENABLE: interp_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stage 1: accept, form floor(frequency * freq_scale / 2^16) mod 2^32
   // ------------------------------------------------------------------
   assign incr_prod = req_frequency * $signed({1'b0, freq_scale_ff});
   assign addr_ext  = AEXT_W'(req_table_address);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         s1_action_ff <= action_type'(req_action);
         s1_addr_ff   <= addr_ext[TABLE_BITS-1:0];
         s1_sample_ff <= req_table_sample;
         s1_incr_ff   <= incr_prod[INCR_SHIFT +: PHASE_W];
      end
   end

   // ------------------------------------------------------------------
   // stage 2: store write for loads, tap reads and phase update for ticks
   // ------------------------------------------------------------------
   assign rd_idx      = phase_ff[PHASE_W-1 -: TABLE_BITS];
   assign rd_idx_next = rd_idx + TABLE_BITS'(1);
   assign wr_en       = s1_v_ff && en2 && (s1_action_ff == ACT_LOAD);

   always_comb begin
      phase_in = phase_ff;
      s2_v_in  = 1'b0;
      if (s1_v_ff) begin
         case (s1_action_ff)
            ACT_TICK: begin
               phase_in = phase_ff + s1_incr_ff;
               s2_v_in  = 1'b1;
            end
            ACT_RESTART: phase_in = start_phase_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         s2_v_ff  <= 1'b0;
      end else if (en2) begin
         phase_ff <= phase_in;
         s2_v_ff  <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_frac_ff   <= phase_ff[FRAC_BITS-1:0];
         s2_interp_ff <= interp_enable_ff;
      end
   end

   // entry at the phase index
   wto_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (en2),
      .rd_addr (rd_idx),
      .rd_data (rd_a)
   );

   // copy of the store for the next entry, wrapping to entry 0
   wto_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (en2),
      .rd_addr (rd_idx_next),
      .rd_data (rd_b)
   );

   // ------------------------------------------------------------------
   // stage 3: tap difference, forced to zero for truncated lookup
   // ------------------------------------------------------------------
   always_comb begin
      if (s2_interp_ff) begin
         s3_diff_in = $signed({rd_b[SAMPLE_BITS-1], rd_b})
                    - $signed({rd_a[SAMPLE_BITS-1], rd_a});
      end else begin
         s3_diff_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_a_ff    <= $signed(rd_a);
         s3_diff_ff <= s3_diff_in;
         s3_frac_ff <= s2_frac_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: floor((b - a) * frac / 2^FRAC_BITS)
   // ------------------------------------------------------------------
   assign interp_prod = s3_diff_ff * $signed({1'b0, s3_frac_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en4) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_a_ff    <= s3_a_ff;
         s4_term_ff <= interp_prod[FRAC_BITS +: DIFF_W];
      end
   end

   // ------------------------------------------------------------------
   // output register: a plus scaled difference, always within a and b
   // ------------------------------------------------------------------
   assign sum_in = $signed({s4_a_ff[SAMPLE_BITS-1], s4_a_ff}) + s4_term_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_sample_ff <= sum_in[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // the phase moves only when an item leaves stage 1
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && !(s1_v_ff && en2) |=> $stable(phase_ff))
      else $error("phase changed without an item");

   // a finished sample in stage 4 is not dropped while the output is blocked
   a_s4_kept: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff && !en_out |=> s4_v_ff && $stable(s4_term_ff))
      else $error("stage 4 lost its sample");

   // no response appears without a sample coming out of stage 4
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !reset && !rsp_valid_ff && !s4_v_ff |=> !rsp_valid_ff)
      else $error("response without a tick");

   // a tick leaving stage 1 always enters the read stage
   a_tick_read: assert property (@(posedge clock) disable iff (reset)
      !reset && s1_v_ff && en2 && (s1_action_ff == ACT_TICK) |=> s2_v_ff)
      else $error("tick lost at store read");
`endif

endmodule

`default_nettype wire
